### rtl/core/gdps_pkg.sv
// Shared types and constants for the granular delay pitch shifter.
// No dependencies; the other files that use it refer to it by scoped names.
package gdps_pkg;

	localparam int SAMPLE_W = 16;
	localparam int RATIO_W  = 17;
	localparam int FRAC_W   = 16;

	localparam int RING_DEPTH_DEF = 8192;
	localparam int GRAIN_LEN_DEF  = 1024;
	localparam int BASE_DELAY_DEF = 2048;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_in;
		logic [RATIO_W-1:0]         pitch_ratio;
	} in_beat_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
	} out_beat_t;

	// step enables from the sequencer to the arithmetic path
	typedef struct packed {
		logic ld_prod;
		logic prod_sel_b;
		logic ld_ip;
		logic ld_wa;
		logic ld_wb;
		logic ld_tot;
		logic ld_div;
	} mac_ctl_t;

endpackage

### rtl/core/gdps_stream_if.sv
// Valid/ready stream channel carrying one beat of type beat_t.
// Depends on nothing; beat types come from gdps_pkg at instantiation.
interface gdps_stream_if #(parameter type beat_t = logic);

	logic  valid;
	logic  ready;
	beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

### rtl/core/granular_delay_pitch_shifter.sv
// Granular delay-line pitch shifter top level: ring RAM, head state, sequencer, output register.
// Sequencer per accepted sample: two RAM read states (RDA, RDB), five multiply/round steps
// (IPA, WA, WB, TOT, DIV), then OUT; no new sample is taken until OUT loads the output register.
// Reset: asynchronous; then a clearing pass zeroes every ring entry, no input taken.
// Depends on gdps_pkg, gdps_stream_if, gdps_ram, gdps_heads, gdps_mac.
module granular_delay_pitch_shifter #(
	parameter int RING_DEPTH = gdps_pkg::RING_DEPTH_DEF,
	parameter int GRAIN_LEN  = gdps_pkg::GRAIN_LEN_DEF,
	parameter int BASE_DELAY = gdps_pkg::BASE_DELAY_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	gdps_stream_if.sink          din,
	gdps_stream_if.source        dout
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam int FW = gdps_pkg::FRAC_W;
	localparam int PW = AW + FW;
	localparam int WW = $clog2(GRAIN_LEN + 1);
	localparam int SW = gdps_pkg::SAMPLE_W;

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_RDA  = 4'd2;
	localparam logic [3:0] ST_RDB  = 4'd3;
	localparam logic [3:0] ST_IPA  = 4'd4;
	localparam logic [3:0] ST_WA   = 4'd5;
	localparam logic [3:0] ST_WB   = 4'd6;
	localparam logic [3:0] ST_TOT  = 4'd7;
	localparam logic [3:0] ST_DIV  = 4'd8;
	localparam logic [3:0] ST_OUT  = 4'd9;

	logic [3:0]           state_q, state_nxt;
	logic [AW-1:0]        clr_q;
	logic                 out_valid_q;
	logic signed [SW-1:0] out_data_q;

	logic                 accept, out_load;
	logic [AW-1:0]        wr_idx;
	logic [PW-1:0]        item_pos_a, item_pos_b, rpos;
	logic [WW-1:0]        item_wt_a, item_wt_b;
	logic [AW-1:0]        ri0, ri1;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [SW-1:0]        ram_wdata, rdata0, rdata1;
	gdps_pkg::mac_ctl_t   ctl;
	logic signed [SW-1:0] result;

	assign din.ready = (state_q == ST_IDLE);
	assign accept    = din.valid && din.ready;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || dout.ready);

	gdps_heads #(
		.RING_DEPTH (RING_DEPTH),
		.GRAIN_LEN  (GRAIN_LEN),
		.BASE_DELAY (BASE_DELAY)
	) u_heads (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.ratio      (din.data.pitch_ratio),
		.wr_idx     (wr_idx),
		.item_pos_a (item_pos_a),
		.item_pos_b (item_pos_b),
		.item_wt_a  (item_wt_a),
		.item_wt_b  (item_wt_b)
	);

	assign rpos = (state_q == ST_RDB) ? item_pos_b : item_pos_a;
	assign ri0  = rpos[PW-1:FW];
	assign ri1  = (ri0 == AW'(RING_DEPTH - 1)) ? '0 : AW'(ri0 + 1'b1);

	assign ram_we    = (state_q == ST_CLR) || accept;
	assign ram_waddr = (state_q == ST_CLR) ? clr_q : wr_idx;
	assign ram_wdata = (state_q == ST_CLR) ? '0 : din.data.sample_in;

	gdps_ram #(
		.WIDTH (SW),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.raddr0 (ri0),
		.raddr1 (ri1),
		.rdata0 (rdata0),
		.rdata1 (rdata1)
	);

	always_comb begin
		ctl            = '0;
		ctl.ld_prod    = (state_q == ST_RDB) || (state_q == ST_IPA);
		ctl.prod_sel_b = (state_q == ST_IPA);
		ctl.ld_ip      = (state_q == ST_IPA) || (state_q == ST_WA);
		ctl.ld_wa      = (state_q == ST_WA);
		ctl.ld_wb      = (state_q == ST_WB);
		ctl.ld_tot     = (state_q == ST_TOT);
		ctl.ld_div     = (state_q == ST_DIV);
	end

	gdps_mac #(
		.GRAIN_LEN (GRAIN_LEN)
	) u_mac (
		.clk    (clk),
		.ctl    (ctl),
		.rdata0 (rdata0),
		.rdata1 (rdata1),
		.frac_a (item_pos_a[FW-1:0]),
		.frac_b (item_pos_b[FW-1:0]),
		.wt_a   (item_wt_a),
		.wt_b   (item_wt_b),
		.result (result)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLR:  if (clr_q == AW'(RING_DEPTH - 1)) state_nxt = ST_IDLE;
			ST_IDLE: if (accept) state_nxt = ST_RDA;
			ST_RDA:  state_nxt = ST_RDB;
			ST_RDB:  state_nxt = ST_IPA;
			ST_IPA:  state_nxt = ST_WA;
			ST_WA:   state_nxt = ST_WB;
			ST_WB:   state_nxt = ST_TOT;
			ST_TOT:  state_nxt = ST_DIV;
			ST_DIV:  state_nxt = ST_OUT;
			ST_OUT:  if (out_load) state_nxt = ST_IDLE;
			default: state_nxt = ST_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_CLR) begin
				clr_q <= AW'(clr_q + 1'b1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= result;
		end
	end

	assign dout.valid           = out_valid_q;
	assign dout.data.sample_out = out_data_q;

	a_accept_starts_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RDA))
		else $error("accepted beat did not start the ring read");

	a_no_out_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> !out_valid_q)
		else $error("output valid during ring clearing");

	a_out_from_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
		else $error("output beat raised outside the final step");

endmodule

### rtl/core/gdps_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies. Read during write at the same address returns old data.
module gdps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

### rtl/core/gdps_heads.sv
// Write index, grain phases and read head positions, updated once per beat.
// Latches the per-beat head positions and window weights. Uses gdps_pkg.
module gdps_heads #(
	parameter int RING_DEPTH = gdps_pkg::RING_DEPTH_DEF,
	parameter int GRAIN_LEN  = gdps_pkg::GRAIN_LEN_DEF,
	parameter int BASE_DELAY = gdps_pkg::BASE_DELAY_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         accept,
	input  logic [gdps_pkg::RATIO_W-1:0]                 ratio,
	output logic [$clog2(RING_DEPTH)-1:0]                wr_idx,
	output logic [$clog2(RING_DEPTH)+gdps_pkg::FRAC_W-1:0] item_pos_a,
	output logic [$clog2(RING_DEPTH)+gdps_pkg::FRAC_W-1:0] item_pos_b,
	output logic [$clog2(GRAIN_LEN+1)-1:0]               item_wt_a,
	output logic [$clog2(GRAIN_LEN+1)-1:0]               item_wt_b
);

	localparam int     AW   = $clog2(RING_DEPTH);
	localparam int     FW   = gdps_pkg::FRAC_W;
	localparam int     PW   = AW + FW;
	localparam int     PHW  = $clog2(GRAIN_LEN);
	localparam int     WW   = $clog2(GRAIN_LEN + 1);
	localparam int     BACK = BASE_DELAY % RING_DEPTH;
	localparam longint SPAN = longint'(RING_DEPTH) << FW;

	logic [AW-1:0]  wr_q;
	logic [PHW-1:0] ph_a_q, ph_b_q;
	logic [PW-1:0]  pos_a_q, pos_b_q;

	logic [AW:0]    wsub;
	logic [AW-1:0]  rst_idx, wr_nxt;
	logic [PW-1:0]  rst_pos;
	logic [PW-1:0]  eff_a, eff_b, adv_a, adv_b, pos_a_nxt, pos_b_nxt;
	logic [PW:0]    sum_a, sum_b;
	logic [PHW-1:0] ph_a_nxt, ph_b_nxt;
	logic           wrap_a, wrap_b;
	logic signed [PHW+1:0] d_a, d_b;
	logic [PHW+1:0] mag_a, mag_b, wfull_a, wfull_b;

	assign wsub    = {1'b0, wr_q} - (AW+1)'(BACK);
	assign rst_idx = wsub[AW] ? AW'(wsub + (AW+1)'(RING_DEPTH)) : wsub[AW-1:0];
	assign rst_pos = {rst_idx, {FW{1'b0}}};

	assign eff_a = (ph_a_q == '0) ? rst_pos : pos_a_q;
	assign eff_b = (ph_b_q == '0) ? rst_pos : pos_b_q;

	assign sum_a = {1'b0, eff_a} + (PW+1)'(ratio);
	assign sum_b = {1'b0, eff_b} + (PW+1)'(ratio);
	assign adv_a = (sum_a >= (PW+1)'(SPAN)) ? PW'(sum_a - (PW+1)'(SPAN)) : sum_a[PW-1:0];
	assign adv_b = (sum_b >= (PW+1)'(SPAN)) ? PW'(sum_b - (PW+1)'(SPAN)) : sum_b[PW-1:0];

	assign wrap_a   = (ph_a_q == PHW'(GRAIN_LEN - 1));
	assign wrap_b   = (ph_b_q == PHW'(GRAIN_LEN - 1));
	assign ph_a_nxt = wrap_a ? '0 : PHW'(ph_a_q + 1'b1);
	assign ph_b_nxt = wrap_b ? '0 : PHW'(ph_b_q + 1'b1);
	assign pos_a_nxt = wrap_a ? rst_pos : adv_a;
	assign pos_b_nxt = wrap_b ? rst_pos : adv_b;

	assign wr_nxt = (wr_q == AW'(RING_DEPTH - 1)) ? '0 : AW'(wr_q + 1'b1);

	// triangular window: GRAIN_LEN - |2*phase - GRAIN_LEN|
	assign d_a     = $signed({1'b0, ph_a_q, 1'b0}) - (PHW+2)'(GRAIN_LEN);
	assign d_b     = $signed({1'b0, ph_b_q, 1'b0}) - (PHW+2)'(GRAIN_LEN);
	assign mag_a   = d_a[PHW+1] ? (PHW+2)'(-d_a) : d_a;
	assign mag_b   = d_b[PHW+1] ? (PHW+2)'(-d_b) : d_b;
	assign wfull_a = (PHW+2)'(GRAIN_LEN) - mag_a;
	assign wfull_b = (PHW+2)'(GRAIN_LEN) - mag_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			ph_a_q  <= '0;
			ph_b_q  <= PHW'(GRAIN_LEN / 2);
			pos_a_q <= '0;
			pos_b_q <= '0;
		end else if (accept) begin
			wr_q    <= wr_nxt;
			ph_a_q  <= ph_a_nxt;
			ph_b_q  <= ph_b_nxt;
			pos_a_q <= pos_a_nxt;
			pos_b_q <= pos_b_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_pos_a <= eff_a;
			item_pos_b <= eff_b;
			item_wt_a  <= WW'(wfull_a);
			item_wt_b  <= WW'(wfull_b);
		end
	end

	assign wr_idx = wr_q;

endmodule

### rtl/core/gdps_mac.sv
// Interpolate, window, sum, round and saturate, one step per sequencer enable.
// Division by GRAIN_LEN*65536 is a shift and a reciprocal multiply. Uses gdps_pkg.
module gdps_mac #(
	parameter int GRAIN_LEN = gdps_pkg::GRAIN_LEN_DEF
) (
	input  logic                                  clk,
	input  gdps_pkg::mac_ctl_t                    ctl,
	input  logic [gdps_pkg::SAMPLE_W-1:0]         rdata0,
	input  logic [gdps_pkg::SAMPLE_W-1:0]         rdata1,
	input  logic [gdps_pkg::FRAC_W-1:0]           frac_a,
	input  logic [gdps_pkg::FRAC_W-1:0]           frac_b,
	input  logic [$clog2(GRAIN_LEN+1)-1:0]        wt_a,
	input  logic [$clog2(GRAIN_LEN+1)-1:0]        wt_b,
	output logic signed [gdps_pkg::SAMPLE_W-1:0]  result
);

	localparam int     FW    = gdps_pkg::FRAC_W;
	localparam int     SW    = gdps_pkg::SAMPLE_W;
	localparam int     WW    = $clog2(GRAIN_LEN + 1);
	localparam int     CW    = $clog2(GRAIN_LEN);
	localparam int     PRW   = SW + FW + 1;
	localparam int     WPW   = PRW + WW + 1;
	localparam int     TW    = WPW + 1;
	localparam int     TQW   = TW - FW + 1;
	localparam int     NW    = FW + CW;
	localparam int     KW    = NW + CW;
	localparam int     QPW   = 2 * NW + 1;
	localparam longint RECIP = ((longint'(1) <<< KW) + GRAIN_LEN - 1) / GRAIN_LEN;
	localparam longint HALF  = longint'(GRAIN_LEN) * 32768;
	localparam longint SAT_P = longint'(GRAIN_LEN) * 32768;
	localparam longint SAT_N = longint'(GRAIN_LEN) * 32769;
	localparam logic [FW:0] ONE_Q = {1'b1, {FW{1'b0}}};

	logic [FW-1:0]          frac;
	logic [FW:0]            coef0, coef1;
	logic signed [PRW-1:0]  s0_x, s1_x, c0_x, c1_x, p0, p1;
	logic signed [PRW-1:0]  m0_s1, m1_s1, ip_s2;
	logic signed [WPW-1:0]  ip_x, wt_x, wp;
	logic signed [WPW-1:0]  pa_s3, pb_s3;
	logic signed [TW-1:0]   total;
	logic [TW-1:0]          mag;
	logic [TW:0]            rnd;
	logic [TQW-1:0]         t_s4;
	logic                   neg_s4, neg_s5, satp_s5, satn_s5;
	logic [QPW-1:0]         qp;
	logic [SW-1:0]          q_s5, q_neg;

	assign frac  = ctl.prod_sel_b ? frac_b : frac_a;
	assign coef1 = {1'b0, frac};
	assign coef0 = ONE_Q - coef1;
	assign s0_x  = PRW'($signed(rdata0));
	assign s1_x  = PRW'($signed(rdata1));
	assign c0_x  = PRW'($signed({1'b0, coef0}));
	assign c1_x  = PRW'($signed({1'b0, coef1}));
	assign p0    = s0_x * c0_x;
	assign p1    = s1_x * c1_x;

	assign ip_x = WPW'(ip_s2);
	assign wt_x = WPW'($signed({1'b0, (ctl.ld_wb ? wt_b : wt_a)}));
	assign wp   = ip_x * wt_x;

	assign total = TW'(pa_s3) + TW'(pb_s3);
	assign mag   = total[TW-1] ? TW'(-total) : total;
	assign rnd   = {1'b0, mag} + (TW+1)'(HALF);

	assign qp = QPW'(t_s4[NW-1:0]) * QPW'(RECIP);

	always_ff @(posedge clk) begin
		if (ctl.ld_prod) begin
			m0_s1 <= p0;
			m1_s1 <= p1;
		end
		if (ctl.ld_ip) begin
			ip_s2 <= m0_s1 + m1_s1;
		end
		if (ctl.ld_wa) begin
			pa_s3 <= wp;
		end
		if (ctl.ld_wb) begin
			pb_s3 <= wp;
		end
		if (ctl.ld_tot) begin
			t_s4   <= rnd[TW:FW];
			neg_s4 <= total[TW-1];
		end
		if (ctl.ld_div) begin
			q_s5    <= qp[KW +: SW];
			neg_s5  <= neg_s4;
			satp_s5 <= (64'(t_s4) >= 64'(SAT_P));
			satn_s5 <= (64'(t_s4) >= 64'(SAT_N));
		end
	end

	assign q_neg = SW'(0) - q_s5;

	always_comb begin
		priority if (neg_s5 && satn_s5) begin
			result = {1'b1, {(SW-1){1'b0}}};
		end else if (neg_s5) begin
			result = q_neg;
		end else if (satp_s5) begin
			result = {1'b0, {(SW-1){1'b1}}};
		end else begin
			result = q_s5;
		end
	end

endmodule
